FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the block checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, idle while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed: %m");

// Check a property on every rising edge, including reset cycles.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed: %m");

`endif

FILE: hw/rtl/edsim_pkg.sv
// ----------------------------------------------------------------------------
// Edit distance similarity package
// Shared codes, constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package edsim_pkg;

  // Input item kinds (carried on s_tuser)
  localparam logic [1:0] KIND_FIRST  = 2'd0;
  localparam logic [1:0] KIND_SECOND = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  localparam int KIND_W = 2;
  localparam int BYTE_W = 8;
  localparam int DIST_W = 7;
  localparam int SIM_W  = 15;

  // 100 percent in Q8
  localparam logic [SIM_W-1:0] SIM_FULL = 15'd25600;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_COL,
    ST_CELL_RD,
    ST_CELL_WR,
    ST_FIN_RD,
    ST_FIN_CAP,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic init_wr;
    logic col_start;
    logic col_next;
    logic cell_wr;
    logic fin_sel;
    logic fin_cap;
    logic mul;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic n1_zero;
    logic n2_zero;
    logic row_last;
    logic col_last;
    logic div_last;
  } stat_t;

endpackage

FILE: hw/rtl/edit_distance_similarity_top.sv
// ----------------------------------------------------------------------------
// Edit distance similarity - top level
// Levenshtein distance and similarity percent of two loaded byte strings.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: s_tuser carries the kind (first string, second string,
//   finish), s_tdata the byte. A load transaction stores the byte; a byte
//   past MAX_LEN is dropped and the truncated flag is raised.
//   A finish transaction runs the table and yields one master transaction
//   with the distance, the Q8 similarity percent and the truncated flag.
//   Each cell update runs a read state and a write state on the cost
//   column memory; the divider yields one quotient bit per cycle.
//   s_tready is low while a finish is computed. Loads are taken while a
//   result waits on the master side; the next result waits in its last
//   step until the receiver takes the previous one.
//   Reset empties both strings, clears the flag and drops any result.
//   When a result is loaded for the master side, both lengths and the flag are cleared.
// ----------------------------------------------------------------------------
module edit_distance_similarity_top #(
  parameter int MAX_LEN = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_byte
  input  logic [1:0]  s_tuser,   // [1:0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [6:0] distance, [21:7] similarity_q8, [23:22] zero
  output logic        m_tuser    // [0] truncated
);

  edsim_pkg::cmd_t  cmd;
  edsim_pkg::stat_t stat;

  logic [edsim_pkg::DIST_W-1:0] distance;
  logic [edsim_pkg::SIM_W-1:0]  similarity_q8;
  logic                         truncated;

  edsim_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .kind     (s_tuser),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  edsim_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .kind          (s_tuser),
    .char_byte     (s_tdata),
    .distance      (distance),
    .similarity_q8 (similarity_q8),
    .truncated     (truncated)
  );

  // Pack the result fields, low field first
  assign m_tdata = {2'b00, similarity_q8, distance};
  assign m_tuser = truncated;

endmodule

FILE: hw/rtl/edsim_ctrl.sv
// ----------------------------------------------------------------------------
// Edit distance similarity controller
// Sequences loading, table sweep, division and result hand-off.
// ----------------------------------------------------------------------------
module edsim_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  input  logic [edsim_pkg::KIND_W-1:0]      kind,
  output logic                              s_tready,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  input  edsim_pkg::stat_t                  stat,
  output edsim_pkg::cmd_t                   cmd
);

  edsim_pkg::state_t state;
  edsim_pkg::state_t state_next;
  logic              out_free;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= edsim_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      edsim_pkg::ST_IDLE: begin
        if (s_tvalid && kind == edsim_pkg::KIND_FINISH) begin
          state_next = edsim_pkg::ST_INIT;
        end
      end
      edsim_pkg::ST_INIT: begin
        if (stat.row_last) begin
          state_next = stat.n2_zero ? edsim_pkg::ST_FIN_RD : edsim_pkg::ST_COL;
        end
      end
      edsim_pkg::ST_COL: begin
        if (!stat.n1_zero) begin
          state_next = edsim_pkg::ST_CELL_RD;
        end else if (stat.col_last) begin
          state_next = edsim_pkg::ST_FIN_RD;
        end
      end
      edsim_pkg::ST_CELL_RD: state_next = edsim_pkg::ST_CELL_WR;
      edsim_pkg::ST_CELL_WR: begin
        if (!stat.row_last) begin
          state_next = edsim_pkg::ST_CELL_RD;
        end else if (stat.col_last) begin
          state_next = edsim_pkg::ST_FIN_RD;
        end else begin
          state_next = edsim_pkg::ST_COL;
        end
      end
      edsim_pkg::ST_FIN_RD:  state_next = edsim_pkg::ST_FIN_CAP;
      edsim_pkg::ST_FIN_CAP: state_next = edsim_pkg::ST_MUL;
      edsim_pkg::ST_MUL:     state_next = edsim_pkg::ST_DIV;
      edsim_pkg::ST_DIV: begin
        if (stat.div_last) begin
          state_next = edsim_pkg::ST_DONE;
        end
      end
      edsim_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = edsim_pkg::ST_IDLE;
        end
      end
      default: state_next = edsim_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      edsim_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.start = (kind == edsim_pkg::KIND_FINISH);
          cmd.load  = (kind == edsim_pkg::KIND_FIRST) || (kind == edsim_pkg::KIND_SECOND);
        end
      end
      edsim_pkg::ST_INIT: cmd.init_wr = 1'b1;
      edsim_pkg::ST_COL: begin
        cmd.col_start = 1'b1;
        cmd.col_next  = stat.n1_zero;
      end
      edsim_pkg::ST_CELL_RD: cmd = '0;
      edsim_pkg::ST_CELL_WR: begin
        cmd.cell_wr  = 1'b1;
        cmd.col_next = stat.row_last;
      end
      edsim_pkg::ST_FIN_RD:  cmd.fin_sel  = 1'b1;
      edsim_pkg::ST_FIN_CAP: cmd.fin_cap  = 1'b1;
      edsim_pkg::ST_MUL:     cmd.mul      = 1'b1;
      edsim_pkg::ST_DIV:     cmd.div_step = 1'b1;
      edsim_pkg::ST_DONE:    cmd.out_load = out_free;
      default:               cmd = '0;
    endcase
  end

  // Result valid: set on load, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

FILE: hw/rtl/edsim_dp.sv
// ----------------------------------------------------------------------------
// Edit distance similarity datapath
// String stores, cost column, cell update, divider and result registers.
// ----------------------------------------------------------------------------
module edsim_dp #(
  parameter int MAX_LEN = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  edsim_pkg::cmd_t                   cmd,
  output edsim_pkg::stat_t                  stat,
  input  logic [edsim_pkg::KIND_W-1:0]      kind,
  input  logic [edsim_pkg::BYTE_W-1:0]      char_byte,
  output logic [edsim_pkg::DIST_W-1:0]      distance,
  output logic [edsim_pkg::SIM_W-1:0]       similarity_q8,
  output logic                              truncated
);

  localparam int CW      = $clog2(MAX_LEN + 1);
  localparam int AW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int NW      = CW + edsim_pkg::SIM_W;
  localparam int SCW     = $clog2(NW);
  localparam int DistW   = edsim_pkg::DIST_W;
  localparam int SimW    = edsim_pkg::SIM_W;
  localparam logic [CW-1:0]  MaxCnt  = CW'(MAX_LEN);
  localparam logic [SCW-1:0] LastStp = SCW'(NW - 1);

  logic [edsim_pkg::BYTE_W-1:0] first_mem  [MAX_LEN];
  logic [edsim_pkg::BYTE_W-1:0] second_mem [MAX_LEN];
  logic [CW-1:0]                cost_mem   [MAX_LEN + 1];

  logic [CW-1:0]  count1;
  logic [CW-1:0]  count2;
  logic           overflow;
  logic [CW-1:0]  row;
  logic [CW-1:0]  col;
  logic [CW-1:0]  up;
  logic [CW-1:0]  diag;
  logic [CW-1:0]  cost_rd;
  logic [edsim_pkg::BYTE_W-1:0] first_rd;
  logic [edsim_pkg::BYTE_W-1:0] second_rd;
  logic [CW-1:0]  dist_val;
  logic [NW-1:0]  num;
  logic [CW-1:0]  rem;
  logic [SCW-1:0] step;

  logic [CW-1:0]  longest;
  logic [CW-1:0]  row_m1;
  logic [CW-1:0]  col_m1;
  logic [CW-1:0]  rd_addr;
  logic           cost_we;
  logic [CW-1:0]  cost_waddr;
  logic [CW-1:0]  cost_wdata;
  logic [CW:0]    del_c;
  logic [CW:0]    ins_c;
  logic [CW:0]    sub_c;
  logic [CW:0]    min_c;
  logic [CW-1:0]  cell_val;
  logic [CW:0]    shifted;
  logic           wr_first;
  logic           wr_second;

  assign longest = (count1 > count2) ? count1 : count2;
  assign row_m1  = row - 1'b1;
  assign col_m1  = col - 1'b1;
  assign rd_addr = cmd.fin_sel ? count1 : row;

  assign wr_first  = cmd.load && kind == edsim_pkg::KIND_FIRST  && count1 < MaxCnt;
  assign wr_second = cmd.load && kind == edsim_pkg::KIND_SECOND && count2 < MaxCnt;

  // Cell update: min of deletion, insertion and substitution
  always_comb begin
    del_c = {1'b0, cost_rd} + 1'b1;
    ins_c = {1'b0, up} + 1'b1;
    sub_c = {1'b0, diag} + {{CW{1'b0}}, (first_rd != second_rd)};
    min_c = (del_c < ins_c) ? del_c : ins_c;
    if (sub_c < min_c) begin
      min_c = sub_c;
    end
    cell_val = min_c[CW-1:0];
  end

  always_comb begin
    cost_we    = cmd.init_wr || cmd.col_start || cmd.cell_wr;
    cost_waddr = cmd.col_start ? '0 : row;
    if (cmd.init_wr) begin
      cost_wdata = row;
    end else if (cmd.col_start) begin
      cost_wdata = col;
    end else begin
      cost_wdata = cell_val;
    end
  end

  assign shifted = {rem, num[NW-1]};

  // Memories
  always_ff @(posedge clk) begin
    if (wr_first) begin
      first_mem[count1[AW-1:0]] <= char_byte;
    end
    if (wr_second) begin
      second_mem[count2[AW-1:0]] <= char_byte;
    end
    if (cost_we) begin
      cost_mem[cost_waddr] <= cost_wdata;
    end
    first_rd  <= first_mem[row_m1[AW-1:0]];
    second_rd <= second_mem[col_m1[AW-1:0]];
    cost_rd   <= cost_mem[rd_addr];
  end

  // String lengths and drop flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count1   <= '0;
      count2   <= '0;
      overflow <= 1'b0;
    end else if (cmd.out_load) begin
      count1   <= '0;
      count2   <= '0;
      overflow <= 1'b0;
    end else if (cmd.load) begin
      if (wr_first) begin
        count1 <= count1 + 1'b1;
      end
      if (wr_second) begin
        count2 <= count2 + 1'b1;
      end
      if (!wr_first && !wr_second) begin
        overflow <= 1'b1;
      end
    end
  end

  // Sweep, divide and result registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      row <= '0;
      col <= CW'(1);
    end
    if (cmd.init_wr) begin
      row <= row + 1'b1;
    end
    if (cmd.col_start) begin
      up   <= col;
      diag <= col_m1;
      row  <= CW'(1);
    end
    if (cmd.cell_wr) begin
      up   <= cell_val;
      diag <= cost_rd;
      row  <= row + 1'b1;
    end
    if (cmd.col_next) begin
      col <= col + 1'b1;
    end
    if (cmd.fin_cap) begin
      dist_val <= (cost_rd > longest) ? longest : cost_rd;
    end
    if (cmd.mul) begin
      num  <= NW'(longest - dist_val) * NW'(edsim_pkg::SIM_FULL);
      rem  <= '0;
      step <= '0;
    end
    if (cmd.div_step) begin
      step <= step + 1'b1;
      if (shifted >= {1'b0, longest}) begin
        rem <= CW'(shifted - {1'b0, longest});
        num <= {num[NW-2:0], 1'b1};
      end else begin
        rem <= shifted[CW-1:0];
        num <= {num[NW-2:0], 1'b0};
      end
    end
    if (cmd.out_load) begin
      distance      <= DistW'(dist_val);
      similarity_q8 <= (longest == '0) ? edsim_pkg::SIM_FULL : num[SimW-1:0];
      truncated     <= overflow;
    end
  end

  assign stat.n1_zero  = (count1 == '0);
  assign stat.n2_zero  = (count2 == '0);
  assign stat.row_last = (row == count1);
  assign stat.col_last = (col == count2);
  assign stat.div_last = (step == LastStp);

endmodule

FILE: hw/rtl/edsim_checker.sv
// ----------------------------------------------------------------------------
// Edit distance similarity checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module edsim_assertions #(
  parameter int MAX_LEN = 64
) (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tuser
);

  localparam bit NarrowDist = (MAX_LEN < 128);

  logic [24:0] res_bus;
  logic [6:0]  res_dist;
  logic [14:0] res_sim;
  logic        zero_dist;
  logic        full_sim;

  assign res_bus   = {m_tuser, m_tdata};
  assign res_dist  = m_tdata[6:0];
  assign res_sim   = m_tdata[21:7];
  assign zero_dist = NarrowDist && (res_dist == 7'd0);
  assign full_sim  = (res_sim == edsim_pkg::SIM_FULL);

  // Hold a stalled result
  `ASSERT_CLK(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(res_bus))

  // Drop any result on reset
  `ASSERT_ALWAYS(a_rst_clear, clk, rst |=> !m_tvalid)

  // Similarity never exceeds 100 percent
  `ASSERT_CLK(a_sim_range, clk, rst, m_tvalid |-> res_sim <= edsim_pkg::SIM_FULL)

  // Equal strings report full similarity
  `ASSERT_CLK(a_zero_dist, clk, rst, m_tvalid && zero_dist |-> full_sim)

endmodule

bind edit_distance_similarity_top edsim_assertions #(
  .MAX_LEN (MAX_LEN)
) u_edsim_assertions (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

FILE: dv/edsim_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Edit distance similarity checker
// Mirrors both loaded strings, predicts the score of each finish and
// compares it with the master-side transactions in order.
// ----------------------------------------------------------------------------
module edsim_checker #(
  parameter int MAX_LEN = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  input  logic        m_tuser,
  output int          mismatch_count,
  output int          scores_due,
  output int          scores_checked
);

  localparam int DIST_W = edsim_pkg::DIST_W;
  localparam int SIM_W  = edsim_pkg::SIM_W;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [SIM_W-1:0]  similarity_q8;
    logic              truncated;
  } score_t;

  logic [edsim_pkg::BYTE_W-1:0] first_text  [MAX_LEN];
  logic [edsim_pkg::BYTE_W-1:0] second_text [MAX_LEN];
  int                first_len;
  int                second_len;
  logic              dropped_byte;
  score_t            pending_scores [$];
  int                fail_tally;
  int                checked_tally;

  // Single-column Levenshtein table over the mirrored strings.
  function automatic int unsigned levenshtein_cost(input int n1, input int n2);
    int unsigned column [MAX_LEN+1];
    int unsigned diag;
    int unsigned saved;
    int unsigned sub;
    int unsigned best;
    for (int r = 0; r <= n1; r++) column[r] = r;
    for (int c = 1; c <= n2; c++) begin
      column[0] = c;
      diag = c - 1;
      for (int r = 1; r <= n1; r++) begin
        saved = column[r];
        sub = diag + ((first_text[r-1] == second_text[c-1]) ? 0 : 1);
        best = column[r] + 1;
        if (column[r-1] + 1 < best) best = column[r-1] + 1;
        if (sub < best) best = sub;
        column[r] = best;
        diag = saved;
      end
    end
    return column[n1];
  endfunction

  task automatic note_mismatch(input string msg);
    fail_tally++;
    if (fail_tally <= 10) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  task automatic absorb_item(input logic [1:0] kind, input logic [7:0] value);
    score_t score;
    int unsigned longest;
    int unsigned best_dist;
    int unsigned full_scale;
    full_scale = edsim_pkg::SIM_FULL;
    case (kind)
      edsim_pkg::KIND_FIRST: begin
        if (first_len < MAX_LEN) begin
          first_text[first_len] = value;
          first_len++;
        end else begin
          dropped_byte = 1'b1;
        end
      end
      edsim_pkg::KIND_SECOND: begin
        if (second_len < MAX_LEN) begin
          second_text[second_len] = value;
          second_len++;
        end else begin
          dropped_byte = 1'b1;
        end
      end
      edsim_pkg::KIND_FINISH: begin
        longest = (first_len > second_len) ? first_len : second_len;
        if (longest == 0) begin
          best_dist = 0;
          score.similarity_q8 = edsim_pkg::SIM_FULL;
        end else begin
          best_dist = levenshtein_cost(first_len, second_len);
          if (best_dist > longest) best_dist = longest;
          score.similarity_q8 = SIM_W'(((longest - best_dist) * full_scale) / longest);
        end
        score.distance  = DIST_W'(best_dist);
        score.truncated = dropped_byte;
        pending_scores.push_back(score);
        first_len    = 0;
        second_len   = 0;
        dropped_byte = 1'b0;
      end
      default: ;  // unused kind: no state change
    endcase
  endtask

  task automatic check_score(input logic [23:0] data, input logic flag);
    score_t want;
    logic [DIST_W-1:0] got_dist;
    logic [SIM_W-1:0]  got_sim;
    logic [23-DIST_W-SIM_W:0] got_pad;
    got_dist = data[DIST_W-1:0];
    got_sim  = data[DIST_W+SIM_W-1:DIST_W];
    got_pad  = data[23:DIST_W+SIM_W];
    if (pending_scores.size() == 0) begin
      note_mismatch($sformatf("unexpected result dist=%0d sim_q8=%0d trunc=%0d",
                              got_dist, got_sim, flag));
      return;
    end
    want = pending_scores.pop_front();
    checked_tally++;
    if (got_dist !== want.distance || got_sim !== want.similarity_q8 ||
        flag !== want.truncated || got_pad !== '0) begin
      note_mismatch($sformatf({"result %0d: expected dist=%0d sim_q8=%0d trunc=%0d, ",
                               "got dist=%0d sim_q8=%0d trunc=%0d pad=%0h"},
                              checked_tally, want.distance, want.similarity_q8,
                              want.truncated, got_dist, got_sim, flag, got_pad));
    end
  endtask

  // Check the result before absorbing a new item: a result never belongs to
  // a finish taken on the same edge.
  always @(posedge clk) begin
    if (rst) begin
      first_len    = 0;
      second_len   = 0;
      dropped_byte = 1'b0;
      pending_scores.delete();
    end else begin
      if (m_tvalid && m_tready) check_score(m_tdata, m_tuser);
      if (s_tvalid && s_tready) absorb_item(s_tuser, s_tdata);
    end
    mismatch_count <= fail_tally;
    scores_checked <= checked_tally;
    scores_due     <= pending_scores.size();
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Edit distance similarity testbench
// Loads pairs of byte strings, finishes them and lets the checker score
// every result; both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb;

  localparam int MAX_LEN        = 64;
  localparam int TARGET_ITEMS   = 1500;
  // Covers the worst finish plus stalls on both sides, with margin.
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int TAIL_CYCLES    = 50;
  // Kind code the block must ignore
  localparam logic [edsim_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] char_byte
  logic [1:0]  s_tuser;   // [1:0] kind
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // [6:0] distance, [21:7] similarity_q8, [23:22] zero
  logic        m_tuser;   // [0] truncated

  int mismatch_count;
  int scores_due;
  int scores_checked;
  int items_sent;
  int finishes_sent;
  int spare_sent;
  int overflow_sets;
  int idle_cycles;
  bit steady_source;

  edit_distance_similarity_top #(
    .MAX_LEN (MAX_LEN)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  edsim_checker #(
    .MAX_LEN (MAX_LEN)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .mismatch_count (mismatch_count),
    .scores_due     (scores_due),
    .scores_checked (scores_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, a few long ones; zero means no idling.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Keep most strings short so the table stays cheap; big ones may overflow.
  function automatic int pick_len(input bit big);
    int roll;
    roll = $urandom_range(0, 99);
    if (big || roll >= 95) return $urandom_range(60, 72);
    if (roll < 65) return $urandom_range(0, 8);
    if (roll < 88) return $urandom_range(9, 24);
    return $urandom_range(25, 64);
  endfunction

  // A narrow alphabet makes matching bytes common.
  function automatic logic [7:0] pick_byte(input bit narrow, input logic [7:0] base);
    if (narrow) return 8'(base + $urandom_range(0, 3));
    return 8'($urandom_range(0, 255));
  endfunction

  // Present one transaction after a random gap and hold it until accepted.
  task automatic push_item(input logic [1:0] kind, input logic [7:0] value);
    int gap;
    gap = steady_source ? 0 : pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (kind == KIND_SPARE) begin
      spare_sent++;
    end else begin
      items_sent++;
      if (kind == edsim_pkg::KIND_FINISH) finishes_sent++;
    end
  endtask

  // Build a string pair (second often an edited copy of the first), load
  // the bytes interleaved with stray unused kinds, then finish.
  task automatic run_random_set(input bit force_big);
    logic [7:0] text_a [$];
    logic [7:0] text_b [$];
    logic [7:0] base;
    bit         narrow;
    int         len_a;
    int         len_b;
    int         ia;
    int         ib;
    int         roll;
    narrow        = ($urandom_range(0, 2) != 0);
    base          = 8'($urandom_range(0, 255));
    steady_source = ($urandom_range(0, 4) == 0);
    // Occasionally finish with nothing loaded
    if ($urandom_range(0, 14) == 0) begin
      push_item(edsim_pkg::KIND_FINISH, 8'($urandom_range(0, 255)));
    end
    len_a = pick_len(force_big);
    for (int k = 0; k < len_a; k++) text_a.push_back(pick_byte(narrow, base));
    if ($urandom_range(0, 1) == 1) begin
      foreach (text_a[k]) begin
        roll = $urandom_range(0, 9);
        if (roll == 0) continue;  // drop the byte
        if (roll == 1) text_b.push_back(pick_byte(narrow, base));
        else text_b.push_back(text_a[k]);
        if (roll == 2) text_b.push_back(pick_byte(narrow, base));
      end
    end else begin
      len_b = pick_len(force_big);
      for (int k = 0; k < len_b; k++) text_b.push_back(pick_byte(narrow, base));
    end
    if (text_a.size() > MAX_LEN || text_b.size() > MAX_LEN) overflow_sets++;
    ia = 0;
    ib = 0;
    while (ia < text_a.size() || ib < text_b.size()) begin
      if ($urandom_range(0, 39) == 0) push_item(KIND_SPARE, 8'($urandom_range(0, 255)));
      if (ib >= text_b.size() || (ia < text_a.size() && $urandom_range(0, 1) == 0)) begin
        push_item(edsim_pkg::KIND_FIRST, text_a[ia]);
        ia++;
      end else begin
        push_item(edsim_pkg::KIND_SECOND, text_b[ib]);
        ib++;
      end
    end
    push_item(edsim_pkg::KIND_FINISH, 8'($urandom_range(0, 255)));
  endtask

  // Receiver: ready for a random run, then stall for a random gap.
  initial begin : result_sink
    int run;
    int gap;
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      m_tready <= 1'b1;
      repeat (run) @(posedge clk);
      gap = pick_gap();
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Watchdog: abort when no transaction moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: %0d cycles without a transaction", idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int set_count;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= edsim_pkg::KIND_FIRST;
    steady_source = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Both strings empty: full similarity
    push_item(edsim_pkg::KIND_FINISH, 8'h00);
    // Unused kind, must leave no trace
    push_item(KIND_SPARE, 8'hff);
    // Extreme bytes, swapped order: distance 2, similarity 0
    push_item(edsim_pkg::KIND_FIRST, 8'h00);
    push_item(edsim_pkg::KIND_FIRST, 8'hff);
    push_item(edsim_pkg::KIND_SECOND, 8'hff);
    push_item(edsim_pkg::KIND_SECOND, 8'h00);
    push_item(edsim_pkg::KIND_FINISH, 8'h5a);
    // Second string empty
    push_item(edsim_pkg::KIND_FIRST, 8'h61);
    push_item(edsim_pkg::KIND_FIRST, 8'h62);
    push_item(edsim_pkg::KIND_FINISH, 8'hff);
    // First string empty
    push_item(edsim_pkg::KIND_SECOND, 8'h80);
    push_item(edsim_pkg::KIND_FINISH, 8'h00);
    // Identical strings
    push_item(edsim_pkg::KIND_FIRST, 8'h7f);
    push_item(edsim_pkg::KIND_SECOND, 8'h7f);
    push_item(edsim_pkg::KIND_FINISH, 8'h01);
    // Fractional similarity that truncates
    push_item(edsim_pkg::KIND_FIRST, 8'h01);
    push_item(edsim_pkg::KIND_FIRST, 8'h02);
    push_item(edsim_pkg::KIND_FIRST, 8'h03);
    push_item(edsim_pkg::KIND_SECOND, 8'h02);
    push_item(edsim_pkg::KIND_FINISH, 8'h00);

    // Random string pairs; every twentieth set draws long strings that may fill a string
    set_count = 0;
    while (items_sent < TARGET_ITEMS) begin
      run_random_set(set_count % 20 == 0);
      set_count++;
    end

    // Drain: advance past the last handshake so the checker count is current
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (scores_due != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d load/finish transactions in %0d finishes, %0d unused-kind",
             items_sent, finishes_sent, spare_sent);
    $display("scored %0d results, %0d string pairs past the length limit",
             scores_checked, overflow_sets);
    if (mismatch_count == 0 && scores_due == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/edsim_pkg.sv
hw/rtl/edsim_ctrl.sv
hw/rtl/edsim_dp.sv
hw/rtl/edit_distance_similarity_top.sv
hw/rtl/edsim_checker.sv
dv/edsim_checker.sv
dv/tb.sv
